FILE: hdl/assembler_token_splitter_defines.svh
// Assertion macros for the assembler token splitter.
// Used by the top level; expects signals clk and rst in scope.
`ifndef ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH
`define ASSEMBLER_TOKEN_SPLITTER_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ATS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ATS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATS_ASSERT_NOW(label, ante, cons, msg)
`define ATS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

FILE: hdl/ats_pkg.sv
// Shared types and character codes for the assembler token splitter.
// No dependencies; imported by ats_decode and assembler_token_splitter.
package ats_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_STRING,
    MODE_MEMORY,
    MODE_COMMENT
  } scan_mode_t;

  // scanner state apart from the line counter
  typedef struct packed {
    scan_mode_t  mode;
    logic [7:0]  length;
  } scan_state_t;

  // one result beat, line number travels beside it
  typedef struct packed {
    logic        char_valid;
    logic [7:0]  token_char;
    logic        token_end;
    logic        too_long;
  } tok_res_t;

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  localparam logic [7:0] MAX_CHARS_RST = 8'd255;

endpackage

FILE: hdl/ats_decode.sv
// Per-byte scanner decision: next state and up to two result beats.
// Pure combinational; depends on ats_pkg.
module ats_decode
  import ats_pkg::*;
#(
  parameter int LINE_BITS = 20
) (
  input  logic [7:0]           src_byte,
  input  logic                 fin,
  input  scan_state_t          state,
  input  logic [LINE_BITS-1:0] line_cnt,
  input  logic [7:0]           max_chars,
  output scan_state_t          state_next,
  output logic [LINE_BITS-1:0] line_next,
  output tok_res_t             res0,
  output tok_res_t             res1,
  output logic [LINE_BITS-1:0] line0,
  output logic [LINE_BITS-1:0] line1,
  output logic [1:0]           n_res
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
  localparam tok_res_t END_ONLY = '{char_valid: 1'b0, token_char: 8'h00,
                                    token_end: 1'b1, too_long: 1'b0};

  logic       is_word, is_str, is_mem, is_cmt, enclosed, open_now, open_after;
  logic       is_lf, is_blank;
  logic       pre_end, add_en, add_end, fits;
  scan_mode_t mode_n;
  logic [7:0] len_n;
  logic [1:0] k;
  tok_res_t   rs0, rs1, add_r;

  assign is_word  = (state.mode == MODE_WORD);
  assign is_str   = (state.mode == MODE_STRING);
  assign is_mem   = (state.mode == MODE_MEMORY);
  assign is_cmt   = (state.mode == MODE_COMMENT);
  assign enclosed = is_str | is_mem;
  assign open_now = is_word | enclosed;
  assign is_lf    = (src_byte == CH_LF);
  assign is_blank = (src_byte == CH_CR) | (src_byte == CH_TAB) | (src_byte == CH_SPACE);

  // classify the byte: optional end mark, optional token byte, new mode
  always_comb begin
    pre_end = 1'b0;
    add_en  = 1'b0;
    add_end = 1'b0;
    mode_n  = state.mode;
    if (is_lf) begin
      pre_end = open_now;
      add_en  = 1'b1;
      add_end = 1'b1;
      mode_n  = MODE_IDLE;
    end else if (is_cmt) begin
      // comment text dropped
    end else if (is_blank) begin
      if (is_word) begin
        pre_end = 1'b1;
        mode_n  = MODE_IDLE;
      end else if (enclosed) begin
        add_en = 1'b1;
      end
    end else if (src_byte == CH_COMMA) begin
      if (enclosed) begin
        add_en = 1'b1;
      end else begin
        pre_end = is_word;
        add_en  = 1'b1;
        add_end = 1'b1;
        mode_n  = MODE_IDLE;
      end
    end else if (src_byte == CH_QUOTE) begin
      if (is_str) begin
        add_en  = 1'b1;
        add_end = 1'b1;
        mode_n  = MODE_IDLE;
      end else if (!is_word && !is_mem) begin
        add_en = 1'b1;
        mode_n = MODE_STRING;
      end
    end else if (src_byte == CH_LBRACK) begin
      if (is_str) begin
        add_en = 1'b1;
      end else if (!is_word && !is_mem) begin
        add_en = 1'b1;
        mode_n = MODE_MEMORY;
      end
    end else if (src_byte == CH_RBRACK) begin
      if (is_mem) begin
        add_en  = 1'b1;
        add_end = 1'b1;
        mode_n  = MODE_IDLE;
      end else if (is_str) begin
        add_en = 1'b1;
      end
    end else if (src_byte == CH_SEMI) begin
      if (is_word || enclosed) add_en = 1'b1;
      else mode_n = MODE_COMMENT;
    end else begin
      add_en = 1'b1;
      if (!enclosed) mode_n = MODE_WORD;
    end
  end

  // line counter, saturating
  assign line_next = (is_lf && line_cnt != LINE_MAX) ? line_cnt + 1'b1 : line_cnt;

  // token byte beat after an optional end mark (which clears the length)
  assign fits = (pre_end ? 8'd0 : state.length) < max_chars;
  always_comb begin
    add_r.char_valid = fits;
    add_r.token_char = fits ? src_byte : 8'h00;
    add_r.token_end  = add_end;
    add_r.too_long   = ~fits;
  end

  assign open_after = (mode_n == MODE_WORD) | (mode_n == MODE_STRING) |
                      (mode_n == MODE_MEMORY);

  // assemble beats, then close an open token on the final byte
  always_comb begin
    rs0   = END_ONLY;
    rs1   = END_ONLY;
    k     = 2'd0;
    len_n = state.length;
    if (pre_end) begin
      k     = 2'd1;
      len_n = 8'd0;
    end
    if (add_en) begin
      if (pre_end) rs1 = add_r;
      else rs0 = add_r;
      k = k + 2'd1;
      if (add_end) len_n = 8'd0;
      else if (fits) len_n = len_n + 8'd1;
    end
    if (fin) begin
      if (open_after) begin
        unique case (k)
          2'd0:    k = 2'd1;
          2'd1:    rs0.token_end = 1'b1;
          default: rs1.token_end = 1'b1;
        endcase
      end
      len_n = 8'd0;
    end
  end

  assign res0             = rs0;
  assign res1             = rs1;
  assign n_res            = k;
  assign state_next.mode   = fin ? MODE_IDLE : mode_n;
  assign state_next.length = len_n;
  // the newline token carries the new line; an end mark before it the old one
  assign line0 = (is_lf && !pre_end) ? line_next : line_cnt;
  assign line1 = line_next;

endmodule

FILE: hdl/assembler_token_splitter.sv
// Assembler token splitter: one source byte in, zero to two token beats out.
// Each byte is registered in the input stage and its beats in the result buffer.
// Throughput: one byte per cycle while each byte yields at most one beat and
// out_stall is low; a byte with two beats can stall input (two-entry result buffer).
// Reset (rst, synchronous): idle mode, token length 0, line 1, limit 255,
// pipeline and result buffer empty.
`include "assembler_token_splitter_defines.svh"

module assembler_token_splitter
  import ats_pkg::*;
#(
  parameter int LINE_BITS = 20
) (
  input  logic                 clk,
  input  logic                 rst,
  // configuration write
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           max_token_chars,
  // source bytes
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           source_byte,
  input  logic                 is_final,
  // token beats
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 char_valid,
  output logic [7:0]           token_char,
  output logic                 token_end,
  output logic [LINE_BITS-1:0] line_number,
  output logic                 too_long
);

  logic [7:0]           max_chars;
  scan_state_t          st, st_next;
  logic [LINE_BITS-1:0] line_cnt, line_next;

  logic                 s_v;
  logic [7:0]           s_byte;
  logic                 s_fin;

  tok_res_t             head_res, spare_res, res0, res1;
  logic [LINE_BITS-1:0] head_line, spare_line, line0, line1;
  logic [1:0]           fill, fill_next, n_res;
  tok_res_t             head_res_next, spare_res_next;
  logic [LINE_BITS-1:0] head_line_next, spare_line_next;

  logic                 in_acc, pop, proc;

  // config register, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) max_chars <= MAX_CHARS_RST;
    else if (cfg_valid && cfg_ready) max_chars <= max_token_chars;
  end

  // handshakes
  assign pop      = out_valid & ~out_stall;
  assign proc     = s_v & (({1'b0, fill} + {1'b0, n_res}) <= (3'd2 + {2'b00, pop}));
  assign in_stall = s_v & ~proc;
  assign in_acc   = in_valid & ~in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) s_v <= 1'b0;
    else if (in_acc) s_v <= 1'b1;
    else if (proc) s_v <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s_byte <= source_byte;
      s_fin  <= is_final;
    end
  end

  ats_decode #(.LINE_BITS(LINE_BITS)) u_decode (
    .src_byte   (s_byte),
    .fin        (s_fin),
    .state      (st),
    .line_cnt   (line_cnt),
    .max_chars  (max_chars),
    .state_next (st_next),
    .line_next  (line_next),
    .res0       (res0),
    .res1       (res1),
    .line0      (line0),
    .line1      (line1),
    .n_res      (n_res)
  );

  // scanner state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.mode   <= MODE_IDLE;
      st.length <= 8'd0;
      line_cnt  <= {{(LINE_BITS-1){1'b0}}, 1'b1};
    end else if (proc) begin
      st       <= st_next;
      line_cnt <= line_next;
    end
  end

  // result buffer: head drives the ports, spare holds a second beat
  always_comb begin
    head_res_next   = head_res;
    head_line_next  = head_line;
    spare_res_next  = spare_res;
    spare_line_next = spare_line;
    fill_next       = fill;
    if (pop) begin
      head_res_next  = spare_res;
      head_line_next = spare_line;
      fill_next      = fill_next - 2'd1;
    end
    if (proc && n_res != 2'd0) begin
      if (fill_next == 2'd0) begin
        head_res_next  = res0;
        head_line_next = line0;
      end else begin
        spare_res_next  = res0;
        spare_line_next = line0;
      end
      fill_next = fill_next + 2'd1;
      if (n_res == 2'd2) begin
        spare_res_next  = res1;
        spare_line_next = line1;
        fill_next       = fill_next + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) fill <= 2'd0;
    else fill <= fill_next;
  end
  always_ff @(posedge clk) begin
    head_res   <= head_res_next;
    head_line  <= head_line_next;
    spare_res  <= spare_res_next;
    spare_line <= spare_line_next;
  end

  assign out_valid   = (fill != 2'd0);
  assign char_valid  = head_res.char_valid;
  assign token_char  = head_res.token_char;
  assign token_end   = head_res.token_end;
  assign too_long    = head_res.too_long;
  assign line_number = head_line;

  // checks
  `ATS_ASSERT_NOW(a_fill_bound, 1'b1, fill <= 2'd2, "result buffer overfilled")
  `ATS_ASSERT_NOW(a_stall_needs_item, in_stall, s_v, "input stalled with empty stage")
  `ATS_ASSERT_NEXT(a_line_mono, 1'b1, line_cnt >= $past(line_cnt), "line counter went back")
  `ATS_ASSERT_NEXT(a_final_idle, proc && s_fin, st.mode == MODE_IDLE && st.length == 8'd0,
                   "scanner not idle after final byte")

endmodule

FILE: test/tb.sv
// Self-checking testbench for assembler_token_splitter.
// Depends on ats_pkg and the splitter RTL; a built-in token predictor checks every beat.
`timescale 1ns / 100ps

module tb
  import ats_pkg::*;
();

  localparam int LINE_W         = 20;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_GAP      = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [7:0] b;
    logic       fin;
  } src_item_t;

  typedef struct packed {
    logic              char_valid;
    logic [7:0]        token_char;
    logic              token_end;
    logic [LINE_W-1:0] line;
    logic              too_long;
  } beat_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [7:0]        max_token_chars = 8'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        source_byte = 8'd0;
  logic              is_final = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              char_valid;
  logic [7:0]        token_char;
  logic              token_end;
  logic [LINE_W-1:0] line_number;
  logic              too_long;

  // stimulus and expected beats
  src_item_t pending_bytes[$];
  beat_t     beats_due[$];
  int        pushed_total = 0;
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  bit        steady = 1'b0;
  int        hold_asks = 0;
  int        hold_served = 0;
  int        hold_left = 0;

  // predictor state
  scan_mode_t        tk_mode = MODE_IDLE;
  logic [7:0]        tk_len = 8'd0;
  logic [LINE_W-1:0] tk_line = LINE_W'(1);
  logic [7:0]        tk_limit = MAX_CHARS_RST;
  beat_t             step_beats[2];
  int                step_n;

  assembler_token_splitter #(.LINE_BITS(LINE_W)) dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .max_token_chars (max_token_chars),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .source_byte     (source_byte),
    .is_final        (is_final),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .char_valid      (char_valid),
    .token_char      (token_char),
    .token_end       (token_end),
    .line_number     (line_number),
    .too_long        (too_long)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------

  function automatic bit token_open();
    return tk_mode == MODE_WORD || tk_mode == MODE_STRING || tk_mode == MODE_MEMORY;
  endfunction

  // emit a token byte, or a dropped-byte beat once the token is full
  function automatic void add_token_byte(input logic [7:0] ch, input logic last);
    beat_t bt;
    bt.line      = tk_line;
    bt.token_end = last;
    if (tk_len < tk_limit) begin
      bt.char_valid = 1'b1;
      bt.token_char = ch;
      bt.too_long   = 1'b0;
      tk_len        = tk_len + 8'd1;
    end else begin
      bt.char_valid = 1'b0;
      bt.token_char = 8'd0;
      bt.too_long   = 1'b1;
    end
    if (last) tk_len = 8'd0;
    step_beats[step_n] = bt;
    step_n++;
  endfunction

  // end-only beat
  function automatic void close_token();
    beat_t bt;
    bt.char_valid = 1'b0;
    bt.token_char = 8'd0;
    bt.token_end  = 1'b1;
    bt.line       = tk_line;
    bt.too_long   = 1'b0;
    tk_len        = 8'd0;
    step_beats[step_n] = bt;
    step_n++;
  endfunction

  function automatic void tokenize(input logic [7:0] b, input logic fin);
    bit inside_tok;
    step_n     = 0;
    inside_tok = (tk_mode == MODE_STRING || tk_mode == MODE_MEMORY);
    if (b == CH_LF) begin
      if (token_open()) close_token();
      if (tk_line != '1) tk_line = tk_line + 1'b1;
      tk_mode = MODE_IDLE;
      add_token_byte(b, 1'b1);
    end else if (tk_mode == MODE_COMMENT) begin
      // comment text is dropped
    end else if (b == CH_CR || b == CH_TAB || b == CH_SPACE) begin
      if (tk_mode == MODE_WORD) begin
        close_token();
        tk_mode = MODE_IDLE;
      end else if (inside_tok) begin
        add_token_byte(b, 1'b0);
      end
    end else if (b == CH_COMMA) begin
      if (inside_tok) begin
        add_token_byte(b, 1'b0);
      end else begin
        if (tk_mode == MODE_WORD) close_token();
        tk_mode = MODE_IDLE;
        add_token_byte(b, 1'b1);
      end
    end else if (b == CH_QUOTE) begin
      if (tk_mode == MODE_STRING) begin
        add_token_byte(b, 1'b1);
        tk_mode = MODE_IDLE;
      end else if (tk_mode != MODE_WORD && tk_mode != MODE_MEMORY) begin
        add_token_byte(b, 1'b0);
        tk_mode = MODE_STRING;
      end
    end else if (b == CH_LBRACK) begin
      if (tk_mode == MODE_STRING) begin
        add_token_byte(b, 1'b0);
      end else if (tk_mode != MODE_WORD && tk_mode != MODE_MEMORY) begin
        add_token_byte(b, 1'b0);
        tk_mode = MODE_MEMORY;
      end
    end else if (b == CH_RBRACK) begin
      if (tk_mode == MODE_MEMORY) begin
        add_token_byte(b, 1'b1);
        tk_mode = MODE_IDLE;
      end else if (tk_mode == MODE_STRING) begin
        add_token_byte(b, 1'b0);
      end
    end else if (b == CH_SEMI) begin
      if (tk_mode == MODE_WORD || inside_tok) add_token_byte(b, 1'b0);
      else tk_mode = MODE_COMMENT;
    end else begin
      add_token_byte(b, 1'b0);
      if (!inside_tok) tk_mode = MODE_WORD;
    end

    // last byte of the source closes whatever is open
    if (fin) begin
      if (token_open()) begin
        if (step_n > 0) step_beats[step_n-1].token_end = 1'b1;
        else close_token();
      end
      tk_mode = MODE_IDLE;
      tk_len  = 8'd0;
    end

    for (int i = 0; i < step_n; i++) beats_due.push_back(step_beats[i]);
  endfunction

  // ---------------------------------------------------------------
  // Source driver
  // ---------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        tokenize(source_byte, is_final);
        void'(pending_bytes.pop_front());
      end
      // a stalled beat holds; otherwise offer the next byte or idle
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() > 0 && (steady || $urandom_range(99) >= 17)) begin
          in_valid    <= 1'b1;
          source_byte <= pending_bytes[0].b;
          is_final    <= pending_bytes[0].fin;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------
  // Beat monitor and receiver stall
  // ---------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (beats_due.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual char %b/%h end %b line %0d long %b",
                   $time, char_valid, token_char, token_end, line_number, too_long);
          mismatch_count++;
        end else begin
          want = beats_due.pop_front();
          check_field("char_valid", 32'(want.char_valid), 32'(char_valid));
          check_field("token_char", 32'(want.token_char), 32'(token_char));
          check_field("token_end", 32'(want.token_end), 32'(token_end));
          check_field("line_number", 32'(want.line), 32'(line_number));
          check_field("too_long", 32'(want.too_long), 32'(too_long));
        end
      end
      // long hold-off on request, else random stalls
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (hold_asks != hold_served) begin
        hold_served <= hold_asks;
        hold_left   <= HOLD_CYCLES;
        out_stall   <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 17);
      end
    end
  end

  // watchdog: cycles in which no beat moves on any channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d beats still due",
               $time, quiet_cycles, beats_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------
  task automatic push_byte(input logic [7:0] b, input logic fin);
    src_item_t it;
    it.b   = b;
    it.fin = fin;
    pending_bytes.push_back(it);
    pushed_total++;
  endtask

  task automatic push_text(input string s, input logic fin_last);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], fin_last && (i == s.len() - 1));
  endtask

  // any byte that is not a delimiter
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CH_LF || b == CH_CR || b == CH_TAB || b == CH_SPACE || b == CH_COMMA ||
           b == CH_QUOTE || b == CH_LBRACK || b == CH_RBRACK || b == CH_SEMI);
    return b;
  endfunction

  function automatic logic [7:0] byte_other(input logic [7:0] a, input logic [7:0] c);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == a || b == c);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_CR;
    endcase
  endfunction

  // string or memory reference, optionally left open
  task automatic push_enclosed(input logic [7:0] open_ch, input logic [7:0] close_ch,
                               input int n, input bit terminate);
    push_byte(open_ch, 1'b0);
    repeat (n) push_byte(byte_other(CH_LF, close_ch), 1'b0);
    if (terminate) push_byte(close_ch, 1'b0);
  endtask

  // one source line with random content
  task automatic gen_line();
    int ntok;
    int n;
    ntok = $urandom_range(1, 5);
    for (int t = 0; t < ntok; t++) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 6);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          repeat (n + 1) push_byte(word_byte(), 1'b0);
          push_byte(($urandom_range(0, 3) == 0) ? CH_COMMA : blank_byte(), 1'b0);
        end
        4: push_byte(CH_COMMA, 1'b0);
        5, 6: push_enclosed(CH_QUOTE, CH_QUOTE, n, $urandom_range(0, 6) != 0);
        7, 8: push_enclosed(CH_LBRACK, CH_RBRACK, n, $urandom_range(0, 6) != 0);
        default: push_byte(blank_byte(), 1'b0);
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      push_byte(CH_SEMI, 1'b0);
      repeat ($urandom_range(0, 5)) push_byte(byte_other(CH_LF, CH_LF), 1'b0);
    end
    case ($urandom_range(0, 19))
      0, 1:    push_byte(CH_LF, 1'b1);
      2:       push_byte(word_byte(), 1'b1);
      default: push_byte(CH_LF, 1'b0);
    endcase
  endtask

  // mostly lines, some raw noise with a rare final mark
  task automatic gen_random(input int n);
    int start;
    start = pushed_total;
    while (pushed_total - start < n) begin
      if ($urandom_range(0, 99) < 80) gen_line();
      else repeat ($urandom_range(1, 4))
        push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0);
    end
  endtask

  // wait until every byte is taken and every beat has come, then let the pipe settle
  task automatic drain();
    while (pending_bytes.size() != 0 || in_valid || beats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    @(posedge clk);
    cfg_valid       <= 1'b1;
    max_token_chars <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tk_limit = v;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: delimiters in idle, word, string, memory and comment mode, byte extremes, final mark cases
    push_text("m a,[;]'c[ ,'", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CH_RBRACK, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_LF, 1'b0);
    push_text(";x\n", 1'b0);
    push_text("[q", 1'b1);
    push_byte(CH_QUOTE, 1'b1);
    drain();

    // one-byte tokens: most bytes overflow
    write_limit(8'd1);
    gen_random(70);
    drain();

    // widest limit, one string long enough to overflow it, receiver hold-off
    write_limit(8'd255);
    gen_random(40);
    push_enclosed(CH_QUOTE, CH_QUOTE, 258, 1'b1);
    push_byte(CH_LF, 1'b0);
    gen_random(30);
    hold_asks++;
    drain();

    // no idling on either side
    write_limit(8'd3);
    steady = 1'b1;
    gen_random(100);
    drain();
    steady = 1'b0;

    write_limit(8'($urandom_range(2, 20)));
    gen_random(80);
    hold_asks++;
    drain();

    write_limit(8'($urandom_range(1, 255)));
    gen_random(50);
    drain();

    write_limit(8'd2);
    gen_random(40);
    drain();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/ats_pkg.sv
hdl/ats_decode.sv
hdl/assembler_token_splitter.sv
test/tb.sv
